// File: sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the ray/sphere intersection tester.
// ----------------------------------------------------------------------------
package rsi_pkg;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } rsp_type;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   localparam int LANES      = 3;
   localparam int SQ_RAD_W   = 130;  // discriminant width
   localparam int DIV_NUM_W  = 99;   // |d * m|
   localparam int DIV_DEN_W  = 64;   // a = d.d
   localparam int DIV_QUO_W  = 67;   // quotient magnitude

endpackage

// File: sv/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
   parameter int RAD_W  = 130,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [RAD_W-1:0]      in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [RAD_W/2-1:0]    out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int STEPS  = ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   logic              val_ff  [STEPS];
   logic [RAD_W-1:0]  rad_ff  [STEPS];
   logic [REM_W-1:0]  rem_ff  [STEPS];
   logic [ROOT_W-1:0] root_ff [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic              src_valid;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [SIDE_W-1:0] src_side;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rad   = in_rad;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = val_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      assign cur   = {src_rem, src_rad[RAD_W-1 -: 2]};
      assign trial = (REM_W+2)'({src_root, 2'b01});
      assign ge    = (cur >= trial);

      always_comb begin
         if (ge) begin
            rem_in = REM_W'(cur - trial);
         end else begin
            rem_in = REM_W'(cur);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else if (adv) begin
            val_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= {src_rad[RAD_W-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {src_root[ROOT_W-2:0], ge};
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = val_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: sv/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across lanes. Quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module rsi_div #(
   parameter int LANES  = 3,
   parameter int NUM_W  = 99,
   parameter int DEN_W  = 64,
   parameter int QUO_W  = 67,
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int STEPS = QUO_W;

   logic                          val_ff  [STEPS];
   logic [LANES-1:0][DEN_W-1:0]   rem_ff  [STEPS];
   logic [LANES-1:0][QUO_W-1:0]   low_ff  [STEPS];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff  [STEPS];
   logic [DEN_W-1:0]              den_ff  [STEPS];
   logic [SIDE_W-1:0]             side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic                          src_valid;
      logic [LANES-1:0][DEN_W-1:0]   src_rem;
      logic [LANES-1:0][QUO_W-1:0]   src_low;
      logic [LANES-1:0][QUO_W-1:0]   src_quo;
      logic [DEN_W-1:0]              src_den;
      logic [SIDE_W-1:0]             src_side;
      logic [LANES-1:0][DEN_W:0]     cur;
      logic [LANES-1:0]              ge;
      logic [LANES-1:0][DEN_W-1:0]   rem_in;
      logic [LANES-1:0][QUO_W-1:0]   low_in;
      logic [LANES-1:0][QUO_W-1:0]   quo_in;

      if (k == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src_rem[l] = DEN_W'(in_num[l][NUM_W-1:QUO_W]);
               src_low[l] = in_num[l][QUO_W-1:0];
            end
         end
         assign src_valid = in_valid;
         assign src_quo   = '0;
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = val_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_low   = low_ff[k-1];
         assign src_quo   = quo_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            cur[l] = {src_rem[l], src_low[l][QUO_W-1]};
            ge[l]  = (cur[l] >= {1'b0, src_den});
            if (ge[l]) begin
               rem_in[l] = DEN_W'(cur[l] - {1'b0, src_den});
            end else begin
               rem_in[l] = DEN_W'(cur[l]);
            end
            low_in[l] = {src_low[l][QUO_W-2:0], 1'b0};
            quo_in[l] = {src_quo[l][QUO_W-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else if (adv) begin
            val_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= low_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= src_den;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = val_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: sv/ray_sphere_intersection.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Ray against configured sphere, nearest root point, pipelined.
// ----------------------------------------------------------------------------
// Accepts one ray per cycle while not stalled and returns one transaction
// per ray, in order: 8 stages form a, h = V.D, c and the reduced
// discriminant (multiplies split into partial products of at most 33-bit pieces),
// 65 stages of square root (one root bit each), 4 stages form the per-axis
// offsets, 67 divider stages (one quotient bit each) and 2 stages add the
// origin and saturate. A result stall with a result held freezes the whole pipeline.
// Configuration must be written only while no transaction is in flight.
module ray_sphere_intersection #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rsi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsi_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [30:0] RADIUS_RESET = 31'(64'd1 << FRAC_BITS);

   typedef struct packed {
      logic [66:0]      h;
      logic [63:0]      a;
      logic             hit;
      logic [2:0][31:0] o;
      logic [2:0][31:0] d;
   } sq_side_type;

   typedef struct packed {
      logic             hit;
      logic [2:0]       neg;
      logic [2:0][31:0] o;
   } dv_side_type;

   // configuration
   logic [2:0][31:0] center_ff;
   logic [30:0]      radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= RADIUS_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            rsi_pkg::REG_CENTER_X: center_ff[0] <= pwdata;
            rsi_pkg::REG_CENTER_Y: center_ff[1] <= pwdata;
            rsi_pkg::REG_CENTER_Z: center_ff[2] <= pwdata;
            rsi_pkg::REG_RADIUS:   radius_ff    <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         rsi_pkg::REG_CENTER_X: prdata = center_ff[0];
         rsi_pkg::REG_CENTER_Y: prdata = center_ff[1];
         rsi_pkg::REG_CENTER_Z: prdata = center_ff[2];
         rsi_pkg::REG_RADIUS:   prdata = {1'b0, radius_ff};
         default:               prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // pipeline advance
   logic             rsp_valid_ff;
   rsi_pkg::rsp_type rsp_data_ff;
   logic             adv;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 1: V = O - C
   logic [2:0][31:0] o_in, d_in;
   logic [2:0][32:0] v1_in;
   logic             v1_val_ff;
   logic [2:0][31:0] o1_ff, d1_ff;
   logic [2:0][32:0] v1_ff;

   assign o_in = {req_data.origin_z, req_data.origin_y, req_data.origin_x};
   assign d_in = {req_data.dir_z, req_data.dir_y, req_data.dir_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v1_in[i] = {o_in[i][31], o_in[i]} - {center_ff[i][31], center_ff[i]};
      end
   end

   // stage 2: products
   logic signed [63:0] dsq  [3];
   logic signed [64:0] vdp  [3];
   logic signed [65:0] vvp  [3];
   logic               v2_val_ff;
   logic [62:0]        dd2_ff [3];
   logic [64:0]        vd2_ff [3];
   logic [64:0]        vv2_ff [3];
   logic [61:0]        rr2_in, rr2_ff;
   logic [2:0][31:0]   o2_ff, d2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dsq[i] = $signed(d1_ff[i]) * $signed(d1_ff[i]);
         vdp[i] = $signed(v1_ff[i]) * $signed(d1_ff[i]);
         vvp[i] = $signed(v1_ff[i]) * $signed(v1_ff[i]);
      end
      rr2_in = 62'(radius_ff) * 62'(radius_ff);
   end

   // stage 3: a, h, c
   logic        v3_val_ff;
   logic [63:0] a3_in, a3_ff;
   logic [66:0] h3_in, h3_ff;
   logic [67:0] c3_in, c3_ff;
   logic [2:0][31:0] o3_ff, d3_ff;

   always_comb begin
      a3_in = 64'(dd2_ff[0]) + 64'(dd2_ff[1]) + 64'(dd2_ff[2]);
      h3_in = 67'({{2{vd2_ff[0][64]}}, vd2_ff[0]}) + 67'({{2{vd2_ff[1][64]}}, vd2_ff[1]})
            + 67'({{2{vd2_ff[2][64]}}, vd2_ff[2]});
      c3_in = 68'(vv2_ff[0]) + 68'(vv2_ff[1]) + 68'(vv2_ff[2]) - 68'(rr2_ff);
   end

   // stage 4: magnitudes
   logic        v4_val_ff;
   logic [64:0] habs4_in, habs4_ff;
   logic [65:0] cabs4_in, cabs4_ff;
   logic        cneg4_ff;
   logic [63:0] a4_ff;
   logic [66:0] h4_ff;
   logic [2:0][31:0] o4_ff, d4_ff;

   always_comb begin
      habs4_in = h3_ff[66] ? 65'(67'd0 - h3_ff) : h3_ff[64:0];
      cabs4_in = c3_ff[67] ? 66'(68'd0 - c3_ff) : c3_ff[65:0];
   end

   // stage 5: partial products of h*h and a*|c|
   logic        v5_val_ff;
   logic [65:0] hhh5_ff;
   logic [64:0] hhm5_ff;
   logic [63:0] hhl5_ff;
   logic [63:0] ac00_ff, ac01_ff, ac10_ff, ac11_ff;
   logic [33:0] ac20_ff, ac21_ff;
   logic        cneg5_ff;
   logic [63:0] a5_ff;
   logic [66:0] h5_ff;
   logic [2:0][31:0] o5_ff, d5_ff;

   // stage 6
   logic         v6_val_ff;
   logic [129:0] hh6_in, hh6_ff;
   logic [129:0] acx6_in, acx6_ff, acy6_in, acy6_ff;
   logic [33:0]  acz6_ff;
   logic         cneg6_ff;
   logic [63:0]  a6_ff;
   logic [66:0]  h6_ff;
   logic [2:0][31:0] o6_ff, d6_ff;

   always_comb begin
      hh6_in  = {hhh5_ff, hhl5_ff} + (130'(hhm5_ff) << 33);
      acx6_in = 130'({ac11_ff, ac00_ff}) + (130'(ac01_ff) << 32);
      acy6_in = (130'(ac10_ff) << 32) + (130'(ac20_ff) << 64);
   end

   // stage 7
   logic         v7_val_ff;
   logic [129:0] ac7_in, ac7_ff, hh7_ff;
   logic         cneg7_ff;
   logic [63:0]  a7_ff;
   logic [66:0]  h7_ff;
   logic [2:0][31:0] o7_ff, d7_ff;

   assign ac7_in = acx6_ff + acy6_ff + (130'(acz6_ff) << 96);

   // stage 8: discriminant
   logic         v8_val_ff;
   logic [130:0] e8_in;
   logic [129:0] e8_ff;
   sq_side_type  sq8_in, sq8_ff;

   always_comb begin
      if (cneg7_ff) begin
         e8_in = 131'(hh7_ff) + 131'(ac7_ff);
      end else begin
         e8_in = 131'(hh7_ff) - 131'(ac7_ff);
      end
      sq8_in.h   = h7_ff;
      sq8_in.a   = a7_ff;
      sq8_in.hit = !e8_in[130] && (a7_ff != '0);
      sq8_in.o   = o7_ff;
      sq8_in.d   = d7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_val_ff <= 1'b0;
         v2_val_ff <= 1'b0;
         v3_val_ff <= 1'b0;
         v4_val_ff <= 1'b0;
         v5_val_ff <= 1'b0;
         v6_val_ff <= 1'b0;
         v7_val_ff <= 1'b0;
         v8_val_ff <= 1'b0;
      end else if (adv) begin
         v1_val_ff <= req_valid;
         v2_val_ff <= v1_val_ff;
         v3_val_ff <= v2_val_ff;
         v4_val_ff <= v3_val_ff;
         v5_val_ff <= v4_val_ff;
         v6_val_ff <= v5_val_ff;
         v7_val_ff <= v6_val_ff;
         v8_val_ff <= v7_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ff <= o_in;
         d1_ff <= d_in;
         v1_ff <= v1_in;

         for (int i = 0; i < 3; i++) begin
            dd2_ff[i] <= dsq[i][62:0];
            vd2_ff[i] <= vdp[i][64:0];
            vv2_ff[i] <= vvp[i][64:0];
         end
         rr2_ff <= rr2_in;
         o2_ff  <= o1_ff;
         d2_ff  <= d1_ff;

         a3_ff <= a3_in;
         h3_ff <= h3_in;
         c3_ff <= c3_in;
         o3_ff <= o2_ff;
         d3_ff <= d2_ff;

         habs4_ff <= habs4_in;
         cabs4_ff <= cabs4_in;
         cneg4_ff <= c3_ff[67];
         a4_ff    <= a3_ff;
         h4_ff    <= h3_ff;
         o4_ff    <= o3_ff;
         d4_ff    <= d3_ff;

         hhh5_ff  <= 66'(habs4_ff[64:32]) * 66'(habs4_ff[64:32]);
         hhm5_ff  <= 65'(habs4_ff[64:32]) * 65'(habs4_ff[31:0]);
         hhl5_ff  <= 64'(habs4_ff[31:0]) * 64'(habs4_ff[31:0]);
         ac00_ff  <= 64'(a4_ff[31:0]) * 64'(cabs4_ff[31:0]);
         ac01_ff  <= 64'(a4_ff[31:0]) * 64'(cabs4_ff[63:32]);
         ac10_ff  <= 64'(a4_ff[63:32]) * 64'(cabs4_ff[31:0]);
         ac11_ff  <= 64'(a4_ff[63:32]) * 64'(cabs4_ff[63:32]);
         ac20_ff  <= 34'(a4_ff[31:0]) * 34'(cabs4_ff[65:64]);
         ac21_ff  <= 34'(a4_ff[63:32]) * 34'(cabs4_ff[65:64]);
         cneg5_ff <= cneg4_ff;
         a5_ff    <= a4_ff;
         h5_ff    <= h4_ff;
         o5_ff    <= o4_ff;
         d5_ff    <= d4_ff;

         hh6_ff   <= hh6_in;
         acx6_ff  <= acx6_in;
         acy6_ff  <= acy6_in;
         acz6_ff  <= ac21_ff;
         cneg6_ff <= cneg5_ff;
         a6_ff    <= a5_ff;
         h6_ff    <= h5_ff;
         o6_ff    <= o5_ff;
         d6_ff    <= d5_ff;

         ac7_ff   <= ac7_in;
         hh7_ff   <= hh6_ff;
         cneg7_ff <= cneg6_ff;
         a7_ff    <= a6_ff;
         h7_ff    <= h6_ff;
         o7_ff    <= o6_ff;
         d7_ff    <= d6_ff;

         e8_ff  <= e8_in[129:0];
         sq8_ff <= sq8_in;
      end
   end

   // square root
   logic                         sq_val;
   logic [rsi_pkg::SQ_RAD_W/2-1:0] sq_root;
   sq_side_type                  sq_side;

   rsi_sqrt #(
      .RAD_W  (rsi_pkg::SQ_RAD_W),
      .SIDE_W ($bits(sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_val_ff),
      .in_rad    (e8_ff),
      .in_side   (sq8_ff),
      .out_valid (sq_val),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // stage 9: m = -h - s
   logic             v9_val_ff;
   logic [67:0]      m9_in, m9_ff;
   logic [2:0][31:0] dabs9_in, dabs9_ff;
   logic [2:0]       dneg9_ff;
   logic [63:0]      a9_ff;
   logic             hit9_ff;
   logic [2:0][31:0] o9_ff;

   always_comb begin
      m9_in = 68'd0 - {sq_side.h[66], sq_side.h} - 68'(sq_root);
      for (int i = 0; i < 3; i++) begin
         dabs9_in[i] = sq_side.d[i][31] ? 32'd0 - sq_side.d[i] : sq_side.d[i];
      end
   end

   // stage 10: |m|
   logic             v10_val_ff;
   logic [66:0]      mabs10_in, mabs10_ff;
   logic             mneg10_ff;
   logic [2:0][31:0] dabs10_ff;
   logic [2:0]       dneg10_ff;
   logic [63:0]      a10_ff;
   logic             hit10_ff;
   logic [2:0][31:0] o10_ff;

   assign mabs10_in = m9_ff[67] ? 67'(68'd0 - m9_ff) : m9_ff[66:0];

   // stage 11: |d| * |m| partial products
   logic             v11_val_ff;
   logic [65:0]      p1_11_ff [3];
   logic [64:0]      p0_11_ff [3];
   logic [2:0]       neg11_ff;
   logic [63:0]      a11_ff;
   logic             hit11_ff;
   logic [2:0][31:0] o11_ff;

   // stage 12: numerators
   logic                                        v12_val_ff;
   logic [2:0][rsi_pkg::DIV_NUM_W-1:0]          num12_in, num12_ff;
   dv_side_type                                 dv12_ff;
   logic [63:0]                                 a12_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num12_in[i] = (rsi_pkg::DIV_NUM_W'(p1_11_ff[i]) << 33)
                     + rsi_pkg::DIV_NUM_W'(p0_11_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_val_ff  <= 1'b0;
         v10_val_ff <= 1'b0;
         v11_val_ff <= 1'b0;
         v12_val_ff <= 1'b0;
      end else if (adv) begin
         v9_val_ff  <= sq_val;
         v10_val_ff <= v9_val_ff;
         v11_val_ff <= v10_val_ff;
         v12_val_ff <= v11_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m9_ff    <= m9_in;
         dabs9_ff <= dabs9_in;
         for (int i = 0; i < 3; i++) begin
            dneg9_ff[i] <= sq_side.d[i][31];
         end
         a9_ff    <= sq_side.a;
         hit9_ff  <= sq_side.hit;
         o9_ff    <= sq_side.o;

         mabs10_ff <= mabs10_in;
         mneg10_ff <= m9_ff[67];
         dabs10_ff <= dabs9_ff;
         dneg10_ff <= dneg9_ff;
         a10_ff    <= a9_ff;
         hit10_ff  <= hit9_ff;
         o10_ff    <= o9_ff;

         for (int i = 0; i < 3; i++) begin
            p1_11_ff[i] <= 66'(dabs10_ff[i]) * 66'(mabs10_ff[66:33]);
            p0_11_ff[i] <= 65'(dabs10_ff[i]) * 65'(mabs10_ff[32:0]);
            neg11_ff[i] <= dneg10_ff[i] ^ mneg10_ff;
         end
         a11_ff   <= a10_ff;
         hit11_ff <= hit10_ff;
         o11_ff   <= o10_ff;

         num12_ff    <= num12_in;
         dv12_ff.hit <= hit11_ff;
         dv12_ff.neg <= neg11_ff;
         dv12_ff.o   <= o11_ff;
         a12_ff      <= a11_ff;
      end
   end

   // division by a
   logic                               dv_val;
   logic [2:0][rsi_pkg::DIV_QUO_W-1:0] dv_quo;
   dv_side_type                        dv_side;

   rsi_div #(
      .LANES  (rsi_pkg::LANES),
      .NUM_W  (rsi_pkg::DIV_NUM_W),
      .DEN_W  (rsi_pkg::DIV_DEN_W),
      .QUO_W  (rsi_pkg::DIV_QUO_W),
      .SIDE_W ($bits(dv_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v12_val_ff),
      .in_num    (num12_ff),
      .in_den    (a12_ff),
      .in_side   (dv12_ff),
      .out_valid (dv_val),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // stage 13: signed offsets
   logic             v13_val_ff;
   logic [2:0][67:0] q13_in, q13_ff;
   logic             hit13_ff;
   logic [2:0][31:0] o13_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side.neg[i]) begin
            q13_in[i] = 68'd0 - {1'b0, dv_quo[i]};
         end else begin
            q13_in[i] = {1'b0, dv_quo[i]};
         end
      end
   end

   // stage 14: add origin, saturate
   logic [2:0][68:0] psum;
   logic [2:0][31:0] pnt;
   rsi_pkg::rsp_type rsp_data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psum[i] = {{37{o13_ff[i][31]}}, o13_ff[i]} + {q13_ff[i][67], q13_ff[i]};
         if (psum[i][68:31] == '0 || psum[i][68:31] == '1) begin
            pnt[i] = psum[i][31:0];
         end else if (psum[i][68]) begin
            pnt[i] = 32'h8000_0000;
         end else begin
            pnt[i] = 32'h7fff_ffff;
         end
         if (!hit13_ff) begin
            pnt[i] = '0;
         end
      end
      rsp_data_in.hit     = hit13_ff;
      rsp_data_in.point_x = pnt[0];
      rsp_data_in.point_y = pnt[1];
      rsp_data_in.point_z = pnt[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v13_val_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v13_val_ff   <= dv_val;
         rsp_valid_ff <= v13_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q13_ff      <= q13_in;
         hit13_ff    <= dv_side.hit;
         o13_ff      <= dv_side.o;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: test/ray_sphere_intersection_tb.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection_tb
// Self-checking testbench for the ray/sphere intersection tester.
// ----------------------------------------------------------------------------
// A scoreboard class predicts every ray's hit flag and nearest root point
// with wide exact integer arithmetic. It checks each result transaction in
// order against that prediction. Directed rays come first: tangent, miss,
// zero direction, a root behind the origin, and saturated points. Randomized
// phases follow under several sphere settings, with random result stalls and
// request gaps, one quiet stretch, and one long result hold-off.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_tb;

   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG    = 4000;

   class ray_scoreboard;
      logic signed [31:0] cen_x, cen_y, cen_z;
      logic [30:0]        radius;
      rsi_pkg::rsp_type   pending[$];
      int                 errors, hits, misses;

      function new();
         cen_x  = 0;
         cen_y  = 0;
         cen_z  = 0;
         radius = 31'd65536;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            rsi_pkg::REG_CENTER_X: cen_x  = val;
            rsi_pkg::REG_CENTER_Y: cen_y  = val;
            rsi_pkg::REG_CENTER_Z: cen_z  = val;
            rsi_pkg::REG_RADIUS:   radius = val[30:0];
            default: ;
         endcase
      endfunction

      function rsi_pkg::rsp_type nearest_point(rsi_pkg::req_type r);
         logic signed [191:0] o[3], d[3], v[3];
         logic signed [191:0] a, h, c, e, s, cand, m, q, p, rr;
         rsi_pkg::rsp_type res;
         o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
         d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
         v[0] = o[0] - 192'(cen_x);
         v[1] = o[1] - 192'(cen_y);
         v[2] = o[2] - 192'(cen_z);
         res = '0;
         a = 0; h = 0; c = 0;
         for (int i = 0; i < 3; i++) begin
            a += d[i] * d[i];
            h += v[i] * d[i];
            c += v[i] * v[i];
         end
         if (a == 0) return res;
         rr = $signed({161'd0, radius});
         c -= rr * rr;
         e = h * h - a * c;
         if (e < 0) return res;
         s = 0;
         for (int b = 70; b >= 0; b--) begin
            cand = s | (192'sd1 << b);
            if (cand * cand <= e) s = cand;
         end
         m = -h - s;
         res.hit = 1'b1;
         for (int i = 0; i < 3; i++) begin
            q = (d[i] * m) / a;
            p = o[i] + q;
            if (p > 192'sd2147483647) p = 192'sd2147483647;
            else if (p < -192'sd2147483648) p = -192'sd2147483648;
            case (i)
               0: res.point_x = p[31:0];
               1: res.point_y = p[31:0];
               default: res.point_z = p[31:0];
            endcase
         end
         return res;
      endfunction

      function void note_ray(rsi_pkg::req_type r);
         pending.push_back(nearest_point(r));
      endfunction

      function void check_point(rsi_pkg::rsp_type got);
         rsi_pkg::rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction %h", got);
            return;
         end
         want = pending.pop_front();
         if (want.hit) hits++; else misses++;
         if (got.hit !== want.hit || got.point_x !== want.point_x ||
             got.point_y !== want.point_y || got.point_z !== want.point_z) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected hit %0b (%0d,%0d,%0d) got hit %0b (%0d,%0d,%0d)",
                        want.hit, want.point_x, want.point_y, want.point_z,
                        got.hit, got.point_x, got.point_y, got.point_z);
         end
      endfunction
   endclass

   logic             clock, reset;
   logic             req_valid, req_stall, rsp_valid, rsp_stall;
   rsi_pkg::req_type req_data;
   rsi_pkg::rsp_type rsp_data;
   logic             psel, penable, pwrite, pready;
   logic [3:0]       paddr;
   logic [31:0]      pwdata, prdata;

   ray_scoreboard sb = new();
   bit calm;
   bit hold_go;
   int hold_left;
   int idle_cycles;

   ray_sphere_intersection uut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // result side: check, random stalls, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_point(rsp_data);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_go) begin
         hold_go = 0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_ray(rsi_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.note_ray(r);
      if (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] r);
      csr_write(rsi_pkg::REG_CENTER_X, x);
      csr_write(rsi_pkg::REG_CENTER_Y, y);
      csr_write(rsi_pkg::REG_CENTER_Z, z);
      csr_write(rsi_pkg::REG_RADIUS, r);
   endtask

   function automatic rsi_pkg::req_type make_ray(int span);
      rsi_pkg::req_type r;
      logic signed [31:0] off[3], dv[3];
      int kind;
      kind = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         off[i] = $signed($urandom_range(0, 2 * span)) - span;
         dv[i]  = -off[i] + ($signed($urandom_range(0, span / 4)) - span / 8);
      end
      r.origin_x = sb.cen_x + off[0];
      r.origin_y = sb.cen_y + off[1];
      r.origin_z = sb.cen_z + off[2];
      r.dir_x = dv[0];
      r.dir_y = dv[1];
      r.dir_z = dv[2];
      if (kind < 25) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (kind < 35) begin
         r.dir_x = $signed($urandom_range(0, 8)) - 4;
         r.dir_y = $signed($urandom_range(0, 8)) - 4;
         r.dir_z = $signed($urandom_range(0, 8)) - 4;
      end else if (kind < 40) begin
         r.dir_x = 0;
         r.dir_y = 0;
         r.dir_z = 0;
      end
      return r;
   endfunction

   localparam logic signed [31:0] ONE = 32'sd65536;
   localparam logic signed [31:0] MAXV = 32'h7fffffff;
   localparam logic signed [31:0] MINV = 32'h80000000;

   initial begin
      rsi_pkg::req_type r;
      int span;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // unit sphere at the origin after reset
      send_ray('{-3 * ONE, 0, 0, ONE, 0, 0});           // two roots
      send_ray('{-3 * ONE, ONE, 0, ONE, 0, 0});         // tangent
      send_ray('{-3 * ONE, 2 * ONE, 0, ONE, 0, 0});     // miss
      send_ray('{-3 * ONE, 0, 0, 0, 0, 0});             // zero direction
      send_ray('{3 * ONE, 0, 0, ONE, 0, 0});            // root behind origin
      send_ray('{0, 0, ONE / 2, 0, -ONE, 7});           // origin inside
      send_ray('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
      send_ray('{MINV, MINV, MINV, MINV, MINV, MINV});
      send_ray('{MAXV, 0, 0, MINV, 0, 0});
      send_ray('{MINV, MAXV, MINV, 1, -1, 1});
      send_ray('{0, 0, 0, 1, 0, 0});
      send_ray('{-5 * ONE, 0, 0, 3, 0, 0});
      drain();
      set_sphere(MAXV, MAXV, MAXV, 32'h7fffffff);      // saturating points
      send_ray('{0, 0, 0, ONE, ONE, ONE});
      send_ray('{MINV, MINV, MINV, -ONE, 0, ONE});
      send_ray('{MAXV, MINV, 0, 1, 1, 1});
      drain();
      set_sphere(MINV, MINV, MINV, 0);                  // point sphere
      send_ray('{MINV, MINV, MINV + 5, 0, 0, 1});
      send_ray('{MINV + ONE, MINV, MINV, -ONE, 0, 0});
      send_ray('{0, 0, 0, MINV, MINV, MINV});
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_sphere($urandom_range(0, 1 << 22), -$urandom_range(0, 1 << 22),
                          $urandom, 32'd1 << 20);
            1: set_sphere(MAXV, MINV, 0, 32'h7fffffff);
            2: set_sphere(MINV, MAXV, MINV, 0);
            3: set_sphere($urandom, $urandom, $urandom, $urandom);
            default: set_sphere(0, 0, 0, 32'd3 << 16);
         endcase
         span = (phase == 2) ? 1 << 12 : 1 << 21;
         for (int n = 0; n < 170; n++) begin
            calm = (phase == 4 && n >= 40 && n < 120);
            if (phase == 0 && n == 30) hold_go = 1;
            send_ray(make_ray(span));
         end
         calm = 0;
         drain();
      end

      $display("rays checked: %0d hits, %0d misses over 8 sphere settings",
               sb.hits, sb.misses);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
